// ===== src/mbpw_pkg.sv =====
// Shared constants, types and coordinate helpers of the map block pixel writer.
package mbpw_pkg;

    localparam int SECTION_SIZE    = 16;
    localparam int MACROBLOCK_SIZE = 512;
    localparam int MAP_SIZE        = 1024;

    localparam int BLOCK_W = 16;
    localparam int ROW_W   = 10;
    localparam int CELL_W  = 8;
    localparam int COORD_W = 10;
    localparam int BCOL_W  = 16;
    localparam int COL_W   = $clog2(SECTION_SIZE);
    localparam int YSUM_W  = COORD_W + 1;
    localparam int XSUM_W  = BCOL_W + 1;

    localparam logic [CELL_W-1:0] GRAY_OFFSET = CELL_W'(128);

    typedef struct packed {
        logic                     run_start;
        logic [BLOCK_W-1:0]       block_number;
        logic [ROW_W-1:0]         first_row;
        logic [ROW_W-1:0]         last_row;
        logic signed [CELL_W-1:0] cell_req;
    } t_in_beat;

    typedef struct packed {
        logic [COORD_W-1:0] min_x;
        logic [COORD_W-1:0] min_y;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] max_y;
    } t_box;

    typedef struct packed {
        logic               write_enable;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [CELL_W-1:0]  gray;
        logic               run_done;
        logic               run_aborted;
        t_box               box;
    } t_out_beat;

    typedef struct packed {
        logic               active;
        logic [COORD_W-1:0] base_row;
        logic [BCOL_W-1:0]  base_col;
        logic [ROW_W-1:0]   row_cnt;
        logic [ROW_W-1:0]   end_row;
        logic [COL_W-1:0]   col_cnt;
    } t_run_state;

    localparam t_box BOX_RESET = '{
        min_x: COORD_W'(MAP_SIZE / 2),
        min_y: COORD_W'(MAP_SIZE / 2),
        max_x: COORD_W'(MAP_SIZE / 2),
        max_y: COORD_W'(MAP_SIZE / 2)
    };

    // All sizes are powers of two, so these reduce to shifts and masks.
    function automatic logic [COORD_W-1:0] base_row_of(logic [BLOCK_W-1:0] blk);
        logic [31:0] b;
        logic [31:0] r;
        b = 32'(blk);
        r = ((b * (2 * SECTION_SIZE)) % MACROBLOCK_SIZE
             + (b / MACROBLOCK_SIZE) * MACROBLOCK_SIZE) % MAP_SIZE;
        return COORD_W'(r);
    endfunction

    function automatic logic [BCOL_W-1:0] base_col_of(logic [BLOCK_W-1:0] blk);
        logic [31:0] b;
        logic [31:0] c;
        b = 32'(blk);
        c = ((b / SECTION_SIZE) * SECTION_SIZE) % MACROBLOCK_SIZE
            + (b / MAP_SIZE) * MACROBLOCK_SIZE;
        return BCOL_W'(c);
    endfunction

    // The x corner is rounded to a section, the y corner to two sections.
    function automatic t_box widen_box(t_box b, logic [COORD_W-1:0] px,
                                       logic [COORD_W-1:0] py);
        t_box               nb;
        logic [COORD_W-1:0] mx;
        logic [COORD_W-1:0] my;
        nb = b;
        mx = px & ~COORD_W'(SECTION_SIZE - 1);
        my = py & ~COORD_W'(2 * SECTION_SIZE - 1);
        if (mx < b.min_x) begin
            nb.min_x = mx;
        end else if (mx > b.max_x) begin
            nb.max_x = mx;
        end
        if (my < b.min_y) begin
            nb.min_y = my;
        end else if (my > b.max_y) begin
            nb.max_y = my;
        end
        return nb;
    endfunction

endpackage

// ===== src/mbpw_if.sv =====
// Valid/ready channels that carry map bytes in and pixel writes out.
interface mbpw_in_if
    import mbpw_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     run_start;
    logic [BLOCK_W-1:0]       block_number;
    logic [ROW_W-1:0]         first_row;
    logic [ROW_W-1:0]         last_row;
    logic signed [CELL_W-1:0] cell_req;

    modport source (output valid, run_start, block_number, first_row, last_row, cell_req,
                    input ready);
    modport sink (input valid, run_start, block_number, first_row, last_row, cell_req,
                  output ready);
endinterface

interface mbpw_out_if
    import mbpw_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               write_enable;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [CELL_W-1:0]  gray;
    logic               run_done;
    logic               run_aborted;
    logic [COORD_W-1:0] box_min_x;
    logic [COORD_W-1:0] box_min_y;
    logic [COORD_W-1:0] box_max_x;
    logic [COORD_W-1:0] box_max_y;

    modport source (output valid, write_enable, pixel_x, pixel_y, gray, run_done,
                    run_aborted, box_min_x, box_min_y, box_max_x, box_max_y,
                    input ready);
    modport sink (input valid, write_enable, pixel_x, pixel_y, gray, run_done,
                  run_aborted, box_min_x, box_min_y, box_max_x, box_max_y,
                  output ready);
endinterface

// ===== src/map_block_pixel_writer.sv =====
// A result is registered and is valid in the cycle after its byte is accepted.
// One byte per cycle while the sink takes each result; the run counters move per byte, the box at run end.
// A new byte is taken while the previous result waits, as long as the sink takes that beat.
// Reset (synchronous, active low) ends any run, empties the output register and sets
// all four bounding box corners to the middle of the map.
module map_block_pixel_writer
    import mbpw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbpw_in_if.sink     i_in,
    mbpw_out_if.source  o_out
);

    t_in_beat   beat;
    t_run_state r_state;
    t_run_state n_state;
    t_box       r_box;
    t_box       n_box;
    t_out_beat  r_res;
    t_out_beat  n_res;
    logic       r_valid;
    logic       accept;

    assign beat = '{
        run_start:    i_in.run_start,
        block_number: i_in.block_number,
        first_row:    i_in.first_row,
        last_row:     i_in.last_row,
        cell_req:     i_in.cell_req
    };

    mbpw_step u_step (
        .i_beat  (beat),
        .i_state (r_state),
        .i_box   (r_box),
        .o_state (n_state),
        .o_box   (n_box),
        .o_res   (n_res)
    );

    assign i_in.ready = !r_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_box   <= BOX_RESET;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
                r_box   <= n_box;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.write_enable = r_res.write_enable;
    assign o_out.pixel_x      = r_res.pixel_x;
    assign o_out.pixel_y      = r_res.pixel_y;
    assign o_out.gray         = r_res.gray;
    assign o_out.run_done     = r_res.run_done;
    assign o_out.run_aborted  = r_res.run_aborted;
    assign o_out.box_min_x    = r_res.box.min_x;
    assign o_out.box_min_y    = r_res.box.min_y;
    assign o_out.box_max_x    = r_res.box.max_x;
    assign o_out.box_max_y    = r_res.box.max_y;

    // A beat never both writes a pixel and aborts its run.
    a_write_xor_abort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.write_enable && o_out.run_aborted))
        else $error("pixel write reported on an aborted beat");

    // A beat that ends a run leaves no run active behind it.
    a_end_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (!(r_res.run_done || r_res.run_aborted) || !r_state.active))
        else $error("run still active after done or abort");

    // The box only ever widens, so its corners stay ordered.
    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_box.min_x <= r_box.max_x) && (r_box.min_y <= r_box.max_y))
        else $error("bounding box corners out of order");

    // Corners are stored rounded to the section grid.
    a_box_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_box.min_x & COORD_W'(SECTION_SIZE - 1)) == '0)
        && ((r_box.max_y & COORD_W'(2 * SECTION_SIZE - 1)) == '0))
        else $error("bounding box corner not aligned");

endmodule

// ===== src/mbpw_step.sv =====
// Per-byte run logic: coordinate walk, range check and bounding box update.
module mbpw_step
    import mbpw_pkg::*;
(
    input  t_in_beat   i_beat,
    input  t_run_state i_state,
    input  t_box       i_box,
    output t_run_state o_state,
    output t_box       o_box,
    output t_out_beat  o_res
);

    t_run_state         s;
    t_box               b;
    t_out_beat          res;
    logic [YSUM_W-1:0]  yy;
    logic [XSUM_W-1:0]  xx;

    always_comb begin
        s   = i_state;
        b   = i_box;
        res = '0;
        yy  = '0;
        xx  = '0;

        // A start byte restarts the walk and may itself be the first pixel.
        if (i_beat.run_start) begin
            s.base_row = base_row_of(i_beat.block_number);
            s.base_col = base_col_of(i_beat.block_number);
            s.row_cnt  = i_beat.first_row;
            s.end_row  = i_beat.last_row;
            s.col_cnt  = '0;
            s.active   = 1'b1;
            if (i_beat.first_row > i_beat.last_row) begin
                s.active     = 1'b0;
                res.run_done = 1'b1;
                b            = widen_box(b, '0, '0);
            end
        end

        if (s.active) begin
            yy = YSUM_W'(s.base_row) + YSUM_W'(s.row_cnt);
            xx = XSUM_W'(s.base_col) + XSUM_W'(s.col_cnt);
            if (yy >= YSUM_W'(MAP_SIZE) || xx >= XSUM_W'(MAP_SIZE)) begin
                res.run_aborted = 1'b1;
                s.active        = 1'b0;
            end else begin
                res.write_enable = 1'b1;
                res.pixel_x      = xx[COORD_W-1:0];
                res.pixel_y      = yy[COORD_W-1:0];
                res.gray         = CELL_W'(i_beat.cell_req) ^ GRAY_OFFSET;
                if (s.col_cnt == COL_W'(SECTION_SIZE - 1)) begin
                    s.col_cnt = '0;
                    if (s.row_cnt >= s.end_row) begin
                        s.active     = 1'b0;
                        res.run_done = 1'b1;
                        b            = widen_box(b, xx[COORD_W-1:0], yy[COORD_W-1:0]);
                    end else begin
                        s.row_cnt = s.row_cnt + ROW_W'(1);
                    end
                end else begin
                    s.col_cnt = s.col_cnt + COL_W'(1);
                end
            end
        end

        res.box = b;
    end

    assign o_state = s;
    assign o_box   = b;
    assign o_res   = res;

endmodule

// ===== tb/tb.sv =====
// Testbench for the map block pixel writer: directed table, then random runs checked by a predictor.
module tb
    import mbpw_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM_BYTES = 1450;
    localparam int N_DIR          = 25;

    typedef struct packed {
        logic               we;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [CELL_W-1:0]  gray;
        logic               done;
        logic               abrt;
        logic [COORD_W-1:0] min_x;
        logic [COORD_W-1:0] min_y;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] max_y;
    } t_pixel_res;

    typedef struct {
        t_in_beat   beat;
        bit         typed;
        t_pixel_res want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mbpw_in_if  in_ch ();
    mbpw_out_if out_ch ();

    map_block_pixel_writer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Own copy of the run state and of the bounding box.
    logic               run_on;
    logic [COORD_W-1:0] run_base_row;
    logic [BCOL_W-1:0]  run_base_col;
    logic [ROW_W-1:0]   run_row;
    logic [ROW_W-1:0]   run_last;
    logic [COL_W-1:0]   run_col;
    logic [COORD_W-1:0] box_lo_x, box_lo_y, box_hi_x, box_hi_y;

    t_pixel_res pixel_q [$];
    int         n_err    = 0;
    int         n_active = 0;
    int         src_calm = 0;
    int         snk_calm = 0;

    // The first beat after reset is ignored; the empty run pulls the box corner to the origin;
    // the full run walks all columns of row 0 of block 0; an x beyond the map, a restart that
    // lands below the map, a beat outside any run and the block boundaries follow.
    t_dir_row dir_rows [N_DIR] = '{
        '{'{1'b0, 16'h0000, 10'd0,    10'd0,    8'h00}, 1'b1,
          '{1'b0, 10'd0,  10'd0, 8'd0,   1'b0, 1'b0, 10'd512, 10'd512, 10'd512, 10'd512}},
        '{'{1'b1, 16'h0000, 10'd5,    10'd4,    8'h00}, 1'b1,
          '{1'b0, 10'd0,  10'd0, 8'd0,   1'b1, 1'b0, 10'd0,   10'd0,   10'd512, 10'd512}},
        '{'{1'b1, 16'h0000, 10'd0,    10'd0,    8'h80}, 1'b1,
          '{1'b1, 10'd0,  10'd0, 8'd0,   1'b0, 1'b0, 10'd0,   10'd0,   10'd512, 10'd512}},
        '{'{1'b0, 16'h0000, 10'd0,    10'd0,    8'h7F}, 1'b1,
          '{1'b1, 10'd1,  10'd0, 8'd255, 1'b0, 1'b0, 10'd0,   10'd0,   10'd512, 10'd512}},
        '{'{1'b0, 16'hFFFF, 10'd1023, 10'd1023, 8'hFF}, 1'b0, '0},
        '{'{1'b0, 16'h5555, 10'd341,  10'd682,  8'h55}, 1'b0, '0},
        '{'{1'b0, 16'hAAAA, 10'd682,  10'd341,  8'hAA}, 1'b0, '0},
        '{'{1'b0, 16'h0001, 10'd1,    10'd2,    8'h01}, 1'b0, '0},
        '{'{1'b0, 16'h8000, 10'd512,  10'd0,    8'hFE}, 1'b0, '0},
        '{'{1'b0, 16'h1234, 10'd17,   10'd900,  8'h40}, 1'b0, '0},
        '{'{1'b0, 16'h0F0F, 10'd255,  10'd256,  8'hC0}, 1'b0, '0},
        '{'{1'b0, 16'hF0F0, 10'd768,  10'd3,    8'h20}, 1'b0, '0},
        '{'{1'b0, 16'h00FF, 10'd99,   10'd77,   8'hE0}, 1'b0, '0},
        '{'{1'b0, 16'hFF00, 10'd600,  10'd601,  8'h10}, 1'b0, '0},
        '{'{1'b0, 16'h3C3C, 10'd44,   10'd1000, 8'hF0}, 1'b0, '0},
        '{'{1'b0, 16'hC3C3, 10'd1000, 10'd44,   8'h08}, 1'b0, '0},
        '{'{1'b0, 16'h7FFF, 10'd7,    10'd8,    8'h81}, 1'b0, '0},
        '{'{1'b0, 16'h0000, 10'd0,    10'd0,    8'h01}, 1'b1,
          '{1'b1, 10'd15, 10'd0, 8'd129, 1'b1, 1'b0, 10'd0,   10'd0,   10'd512, 10'd512}},
        '{'{1'b1, 16'hFFFF, 10'd0,    10'd0,    8'h00}, 1'b1,
          '{1'b0, 10'd0,  10'd0, 8'd0,   1'b0, 1'b1, 10'd0,   10'd0,   10'd512, 10'd512}},
        '{'{1'b1, 16'h0000, 10'd1023, 10'd1023, 8'hFF}, 1'b0, '0},
        '{'{1'b1, 16'h0200, 10'd1023, 10'd1023, 8'h05}, 1'b1,
          '{1'b0, 10'd0,  10'd0, 8'd0,   1'b0, 1'b1, 10'd0,   10'd0,   10'd512, 10'd512}},
        '{'{1'b0, 16'h0000, 10'd0,    10'd0,    8'h00}, 1'b1,
          '{1'b0, 10'd0,  10'd0, 8'd0,   1'b0, 1'b0, 10'd0,   10'd0,   10'd512, 10'd512}},
        '{'{1'b1, 16'h03FF, 10'd0,    10'd1,    8'hF9}, 1'b0, '0},
        '{'{1'b1, 16'h0400, 10'd0,    10'd0,    8'h40}, 1'b0, '0},
        '{'{1'b1, 16'h0800, 10'd0,    10'd0,    8'h00}, 1'b1,
          '{1'b0, 10'd0,  10'd0, 8'd0,   1'b0, 1'b1, 10'd0,   10'd0,   10'd512, 10'd512}}
    };

    function automatic logic [COORD_W-1:0] block_row(logic [BLOCK_W-1:0] blk);
        int unsigned b;
        b = 32'(blk);
        return COORD_W'(((b % (MACROBLOCK_SIZE / (2 * SECTION_SIZE))) * 2 * SECTION_SIZE
                         + (b / MACROBLOCK_SIZE) * MACROBLOCK_SIZE) % MAP_SIZE);
    endfunction

    function automatic logic [BCOL_W-1:0] block_col(logic [BLOCK_W-1:0] blk);
        int unsigned b;
        b = 32'(blk);
        return BCOL_W'(((b / SECTION_SIZE) % (MACROBLOCK_SIZE / SECTION_SIZE)) * SECTION_SIZE
                       + (b / MAP_SIZE) * MACROBLOCK_SIZE);
    endfunction

    // Corners snap to a section in x and to two sections in y before the box grows.
    function automatic void grow_box(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        sx = x & ~COORD_W'(SECTION_SIZE - 1);
        sy = y & ~COORD_W'(2 * SECTION_SIZE - 1);
        if (sx < box_lo_x) begin
            box_lo_x = sx;
        end else if (sx > box_hi_x) begin
            box_hi_x = sx;
        end
        if (sy < box_lo_y) begin
            box_lo_y = sy;
        end else if (sy > box_hi_y) begin
            box_hi_y = sy;
        end
    endfunction

    function automatic t_pixel_res predict_pixel(t_in_beat b);
        t_pixel_res         r;
        logic [COORD_W:0]   y;
        logic [BCOL_W:0]    x;
        r = '0;
        if (b.run_start) begin
            run_base_row = block_row(b.block_number);
            run_base_col = block_col(b.block_number);
            run_row      = b.first_row;
            run_last     = b.last_row;
            run_col      = '0;
            run_on       = 1'b1;
            if (b.first_row > b.last_row) begin
                run_on = 1'b0;
                r.done = 1'b1;
                grow_box('0, '0);
            end
        end
        if (run_on) begin
            y = {1'b0, run_base_row} + {1'b0, run_row};
            x = {1'b0, run_base_col} + (BCOL_W + 1)'(run_col);
            if (y >= (COORD_W + 1)'(MAP_SIZE) || x >= (BCOL_W + 1)'(MAP_SIZE)) begin
                r.abrt = 1'b1;
                run_on = 1'b0;
            end else begin
                r.we   = 1'b1;
                r.px   = x[COORD_W-1:0];
                r.py   = y[COORD_W-1:0];
                r.gray = b.cell_req ^ 8'h80;
                if (run_col == COL_W'(SECTION_SIZE - 1)) begin
                    run_col = '0;
                    if (run_row >= run_last) begin
                        run_on = 1'b0;
                        r.done = 1'b1;
                        grow_box(r.px, r.py);
                    end else begin
                        run_row = run_row + ROW_W'(1);
                    end
                end else begin
                    run_col = run_col + COL_W'(1);
                end
            end
        end
        r.min_x = box_lo_x;
        r.min_y = box_lo_y;
        r.max_x = box_hi_x;
        r.max_y = box_hi_y;
        return r;
    endfunction

    // Mostly a randomly drawn idle gap, now and then a calm stretch with none at all.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 3);
    endfunction

    function automatic t_in_beat cont_byte();
        t_in_beat b;
        b.run_start    = 1'b0;
        b.block_number = BLOCK_W'($urandom);
        b.first_row    = ROW_W'($urandom);
        b.last_row     = ROW_W'($urandom);
        b.cell_req     = CELL_W'($urandom);
        return b;
    endfunction

    task automatic send_byte(t_in_beat b, bit typed, t_pixel_res want);
        int         gap;
        bit         counts;
        t_pixel_res p;
        gap = draw_wait(src_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.run_start    = b.run_start;
        in_ch.block_number = b.block_number;
        in_ch.first_row    = b.first_row;
        in_ch.last_row     = b.last_row;
        in_ch.cell_req     = b.cell_req;
        in_ch.valid        = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        counts = b.run_start || run_on;
        p = predict_pixel(b);
        if (counts) begin
            n_active++;
        end
        pixel_q.insert(pixel_q.size(), typed ? want : p);
    endtask

    task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_err++;
        end
    endtask

    task automatic check_pixel();
        t_pixel_res w;
        if (pixel_q.size() == 0) begin
            $error("result beat arrived with nothing expected");
            n_err++;
        end else begin
            w = pixel_q.pop_front();
            cmp_field("write_enable", 32'(w.we),    32'(out_ch.write_enable));
            cmp_field("pixel_x",      32'(w.px),    32'(out_ch.pixel_x));
            cmp_field("pixel_y",      32'(w.py),    32'(out_ch.pixel_y));
            cmp_field("gray",         32'(w.gray),  32'(out_ch.gray));
            cmp_field("run_done",     32'(w.done),  32'(out_ch.run_done));
            cmp_field("run_aborted",  32'(w.abrt),  32'(out_ch.run_aborted));
            cmp_field("box_min_x",    32'(w.min_x), 32'(out_ch.box_min_x));
            cmp_field("box_min_y",    32'(w.min_y), 32'(out_ch.box_min_y));
            cmp_field("box_max_x",    32'(w.max_x), 32'(out_ch.box_max_x));
            cmp_field("box_max_y",    32'(w.max_y), 32'(out_ch.box_max_y));
        end
    endtask

    initial begin
        int stall;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_wait(snk_calm);
            @(negedge i_clk);
            if (stall > 0) begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            check_pixel();
        end
    end

    initial begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        int       kind;
        int       room;
        int       span;
        int       first;
        int       last;
        int       cap;
        int       k;
        t_in_beat b;
        in_ch.valid        = 1'b0;
        in_ch.run_start    = 1'b0;
        in_ch.block_number = '0;
        in_ch.first_row    = '0;
        in_ch.last_row     = '0;
        in_ch.cell_req     = '0;
        i_rst_n            = 1'b0;
        run_on       = 1'b0;
        run_base_row = '0;
        run_base_col = '0;
        run_row      = '0;
        run_last     = '0;
        run_col      = '0;
        box_lo_x     = COORD_W'(MAP_SIZE / 2);
        box_lo_y     = COORD_W'(MAP_SIZE / 2);
        box_hi_x     = COORD_W'(MAP_SIZE / 2);
        box_hi_y     = COORD_W'(MAP_SIZE / 2);
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            send_byte(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
        end

        n_active = 0;
        while (n_active < N_RANDOM_BYTES) begin
            kind = $urandom_range(0, 99);
            if (kind >= 95) begin
                // Stray beats with no run start; they only continue a run left open.
                repeat ($urandom_range(1, 4)) send_byte(cont_byte(), 1'b0, '0);
                continue;
            end
            b = cont_byte();
            b.run_start = 1'b1;
            cap = 64;
            if (kind < 80) begin
                b.block_number = BLOCK_W'($urandom_range(0, 2047));
                room = MAP_SIZE - 1 - int'(block_row(b.block_number));
                if (kind < 70 && kind >= 60) begin
                    // The last rows may fall below the map; the run is then dropped part way.
                    first = room - $urandom_range(0, (room > 0) ? 1 : 0);
                    last  = first + $urandom_range(1, 3);
                    if (last > MAP_SIZE - 1) begin
                        last = MAP_SIZE - 1;
                    end
                end else begin
                    span = $urandom_range(0, 2);
                    if (span > room) begin
                        span = room;
                    end
                    first = $urandom_range(0, 1) ? room - span : $urandom_range(0, room - span);
                    last  = first + span;
                    if (kind >= 70) begin
                        cap = $urandom_range(0, 20);
                    end
                end
                b.first_row = ROW_W'(first);
                b.last_row  = ROW_W'(last);
            end else if (kind < 90) begin
                cap = 48;
            end else begin
                first       = $urandom_range(1, MAP_SIZE - 1);
                b.first_row = ROW_W'(first);
                b.last_row  = ROW_W'($urandom_range(0, first - 1));
            end
            send_byte(b, 1'b0, '0);
            k = 0;
            while (run_on && k < cap) begin
                send_byte(cont_byte(), 1'b0, '0);
                k++;
            end
            if ($urandom_range(0, 3) == 0) begin
                send_byte(cont_byte(), 1'b0, '0);
            end
        end

        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (n_err == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/mbpw_pkg.sv
src/mbpw_if.sv
src/mbpw_step.sv
src/map_block_pixel_writer.sv
tb/tb.sv
